// ----- rtl/core/mct_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse code translator package
// Shared types, character codes and the letter code table.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] LEN_MAX  = 3'd4;
  localparam logic [2:0] LEN_OVER = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_DECODE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0] len;
    logic [3:0] pat;
  } code_t;

  typedef struct packed {
    logic [2:0] sym_len;
    logic [3:0] sym_pat;
    logic [7:0] fin_char;
    logic       fin_valid;
    logic       line_end;
  } job_t;

  function automatic code_t code_of(input logic [4:0] idx);
    code_t c;
    case (idx)
      5'd0:  c = '{3'd2, 4'h1};
      5'd1:  c = '{3'd4, 4'h8};
      5'd2:  c = '{3'd4, 4'hA};
      5'd3:  c = '{3'd3, 4'h4};
      5'd4:  c = '{3'd1, 4'h0};
      5'd5:  c = '{3'd4, 4'h2};
      5'd6:  c = '{3'd3, 4'h6};
      5'd7:  c = '{3'd4, 4'h0};
      5'd8:  c = '{3'd2, 4'h0};
      5'd9:  c = '{3'd4, 4'h7};
      5'd10: c = '{3'd3, 4'h5};
      5'd11: c = '{3'd4, 4'h4};
      5'd12: c = '{3'd2, 4'h3};
      5'd13: c = '{3'd2, 4'h2};
      5'd14: c = '{3'd3, 4'h7};
      5'd15: c = '{3'd4, 4'h6};
      5'd16: c = '{3'd4, 4'hD};
      5'd17: c = '{3'd3, 4'h2};
      5'd18: c = '{3'd3, 4'h0};
      5'd19: c = '{3'd1, 4'h1};
      5'd20: c = '{3'd3, 4'h1};
      5'd21: c = '{3'd4, 4'h1};
      5'd22: c = '{3'd3, 4'h3};
      5'd23: c = '{3'd4, 4'h9};
      5'd24: c = '{3'd4, 4'hB};
      5'd25: c = '{3'd4, 4'hC};
      default: c = '{3'd0, 4'h0};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] letter_of(input logic [3:0] pat, input logic [2:0] len,
                                           input logic bad);
    logic [7:0] r;
    code_t      c;
    r = CH_QUERY;
    if (!bad && len != 3'd0 && len <= LEN_MAX) begin
      for (int i = 25; i >= 0; i--) begin
        c = code_of(5'(i));
        if (c.len == len && c.pat == pat) begin
          r = CH_UA + 8'(i);
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/morse_code_translator_core.sv -----
// ----------------------------------------------------------------------------
// Morse code translator core
// Path: the results of a byte pass through the job queue and the back end's
// job register before they are on the ports.
// Throughput: one input byte per cycle while the job queue has room; the
// output side gives one result per cycle while pop is high and a job is
// loaded; a byte gives zero to five results, set by the back end's counter.
// Reset: asynchronous, active low; clears the line mode, token and queue.
// ----------------------------------------------------------------------------
module morse_code_translator_core import mct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       line_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       last_o,
  output logic       line_done_o
);

  logic accept, job_valid, q_rd, q_empty;
  job_t job, q_data;

  assign accept = push && !full;

  mct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_char_i   (in_char_i),
    .line_end_i  (line_end_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mct_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && job_valid),
    .wr_data_i (job),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  mct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .last_o       (last_o),
    .line_done_o  (line_done_o)
  );

endmodule

// ----- rtl/core/mct_front.sv -----
// ----------------------------------------------------------------------------
// Morse code translator front end
// Accepts bytes, tracks the line mode and token, and issues output jobs.
// ----------------------------------------------------------------------------
module mct_front import mct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       line_end_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  mode_e      mode_q, mode_d;
  logic [3:0] pat_q, pat_d;
  logic [2:0] len_q, len_d;
  logic       bad_q, bad_d;

  logic       is_sym, is_space, is_decode, close_tok, is_letter;
  logic [7:0] up_char;
  code_t      code;
  logic [3:0] tpat;
  logic [2:0] tlen;
  logic       tbad;

  always_comb begin
    is_sym   = (in_char_i == CH_DOT) || (in_char_i == CH_DASH);
    is_space = (in_char_i == CH_SPACE);
    case (mode_q)
      MODE_IDLE:   is_decode = is_sym;
      MODE_DECODE: is_decode = 1'b1;
      default:     is_decode = 1'b0;
    endcase

    tpat = pat_q;
    tlen = len_q;
    tbad = bad_q;
    if (is_sym) begin
      if (len_q < LEN_MAX) begin
        tpat = {pat_q[2:0], in_char_i == CH_DASH};
        tlen = len_q + 3'd1;
      end else begin
        tlen = LEN_OVER;
      end
    end else if (!is_space) begin
      tbad = 1'b1;
    end
    close_tok = (is_space || line_end_i) && (tlen != 3'd0 || tbad);

    up_char   = (in_char_i >= CH_LA && in_char_i <= CH_LZ) ? in_char_i - CASE_OFS
                                                            : in_char_i;
    is_letter = (up_char >= CH_UA) && (up_char <= CH_UZ);
    code      = code_of(5'(up_char - CH_UA));

    job_o.line_end = line_end_i;
    if (is_decode) begin
      job_valid_o     = close_tok || line_end_i;
      job_o.sym_len   = 3'd0;
      job_o.sym_pat   = 4'h0;
      job_o.fin_char  = close_tok ? letter_of(tpat, tlen, tbad) : CH_NUL;
      job_o.fin_valid = close_tok;
    end else begin
      job_valid_o     = 1'b1;
      job_o.sym_len   = is_letter ? code.len : 3'd0;
      job_o.sym_pat   = is_letter ? code.pat : 4'h0;
      job_o.fin_char  = CH_SPACE;
      job_o.fin_valid = 1'b1;
    end
  end

  always_comb begin
    mode_d = mode_q;
    pat_d  = pat_q;
    len_d  = len_q;
    bad_d  = bad_q;
    if (accept_i) begin
      if (line_end_i) begin
        mode_d = MODE_IDLE;
        pat_d  = 4'h0;
        len_d  = 3'd0;
        bad_d  = 1'b0;
      end else begin
        mode_d = is_decode ? MODE_DECODE : MODE_ENCODE;
        if (is_decode) begin
          pat_d = close_tok ? 4'h0 : tpat;
          len_d = close_tok ? 3'd0 : tlen;
          bad_d = close_tok ? 1'b0 : tbad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pat_q  <= 4'h0;
      len_q  <= 3'd0;
      bad_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pat_q  <= pat_d;
      len_q  <= len_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ----- rtl/core/mct_queue.sv -----
// ----------------------------------------------------------------------------
// Morse code translator job queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mct_queue import mct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  input  logic rd_i,
  output job_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_comb begin
    wp_d  = do_wr ? wp_q + 1'b1 : wp_q;
    rp_d  = do_rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/mct_back.sv -----
// ----------------------------------------------------------------------------
// Morse code translator back end
// Expands one job into its symbols and closing character, one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
module mct_back import mct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_data_i,
  output logic       q_rd_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       last_o,
  output logic       line_done_o
);

  logic       busy_q, busy_d;
  job_t       job_q, job_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] sel;
  logic       fin, done;

  assign empty_o = !busy_q;
  assign fin     = (cnt_q == 3'd0);
  assign done    = !busy_q || (pop_i && fin);
  assign q_rd_o  = done && !q_empty_i;
  assign sel     = 2'(cnt_q - 3'd1);

  always_comb begin
    if (fin) begin
      out_char_o   = job_q.fin_char;
      char_valid_o = job_q.fin_valid;
    end else begin
      out_char_o   = job_q.sym_pat[sel] ? CH_DASH : CH_DOT;
      char_valid_o = 1'b1;
    end
    last_o      = fin;
    line_done_o = fin && job_q.line_end;
  end

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    cnt_d  = cnt_q;
    if (q_rd_o) begin
      busy_d = 1'b1;
      job_d  = q_data_i;
      cnt_d  = q_data_i.sym_len;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (pop_i) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- verif/morse_line_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse line translator checker
// Watches both queue ports of the translator. It keeps its own model of the
// line mode and the token being gathered, predicts the characters of every
// accepted byte, and compares each result transaction with the oldest one.
// ----------------------------------------------------------------------------
module morse_line_checker import mct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_char_i,
  input  logic       line_end_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_char_i,
  input  logic       char_valid_i,
  input  logic       last_i,
  input  logic       line_done_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic       done;
  } morse_out_t;

  morse_out_t exp_chars_q[$];

  mode_e      line_mode;
  logic [3:0] tok_pat;
  logic [2:0] tok_len;
  logic       tok_bad;

  function automatic string morse_of(input int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      default: return "--..";
    endcase
  endfunction

  function automatic logic [7:0] token_letter();
    string      tok;
    logic [7:0] r;
    r   = CH_QUERY;
    tok = "";
    if (!tok_bad && tok_len != 3'd0 && tok_len <= LEN_MAX) begin
      for (int k = int'(tok_len) - 1; k >= 0; k--) begin
        if (tok_pat[k]) begin
          tok = {tok, "-"};
        end else begin
          tok = {tok, "."};
        end
      end
      for (int i = 0; i < 26; i++) begin
        if (morse_of(i) == tok) begin
          r = CH_UA + 8'(i);
        end
      end
    end
    return r;
  endfunction

  task automatic clear_token();
    tok_pat = 4'h0;
    tok_len = 3'd0;
    tok_bad = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic e);
    morse_out_t res [6];
    int         n;
    logic [7:0] up;
    string      code;
    n = 0;
    if (line_mode == MODE_IDLE) begin
      line_mode = (c == CH_DOT || c == CH_DASH) ? MODE_DECODE : MODE_ENCODE;
    end
    if (line_mode == MODE_DECODE) begin
      if (c == CH_DOT || c == CH_DASH) begin
        if (tok_len < LEN_MAX) begin
          tok_pat = {tok_pat[2:0], c == CH_DASH};
          tok_len = tok_len + 3'd1;
        end else begin
          tok_len = LEN_OVER;
        end
      end else if (c != CH_SPACE) begin
        tok_bad = 1'b1;
      end
      if ((c == CH_SPACE || e) && (tok_len != 3'd0 || tok_bad)) begin
        res[n] = '{token_letter(), 1'b1, 1'b0, 1'b0};
        n++;
        clear_token();
      end
    end else begin
      up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
      if (up >= CH_UA && up <= CH_UZ) begin
        code = morse_of(int'(up - CH_UA));
        for (int k = 0; k < code.len(); k++) begin
          res[n] = '{code[k], 1'b1, 1'b0, 1'b0};
          n++;
        end
      end
      res[n] = '{CH_SPACE, 1'b1, 1'b0, 1'b0};
      n++;
    end
    if (e) begin
      if (n == 0) begin
        res[n] = '{CH_NUL, 1'b0, 1'b0, 1'b0};
        n++;
      end
      res[n-1].done = 1'b1;
      line_mode = MODE_IDLE;
      clear_token();
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      exp_chars_q.push_back(res[i]);
    end
  endtask

  task automatic compare_char();
    morse_out_t got;
    morse_out_t want;
    got = '{out_char_i, char_valid_i, last_i, line_done_i};
    results_o++;
    if (exp_chars_q.size() == 0) begin
      $display("%0t: unexpected result char=%h valid=%b last=%b done=%b", $time,
               got.ch, got.valid, got.last, got.done);
      fail_count_o++;
    end else begin
      want = exp_chars_q.pop_front();
      if (got !== want) begin
        $display("%0t: expected %h/%b/%b/%b, got %h/%b/%b/%b (char/valid/last/done)",
                 $time, want.ch, want.valid, want.last, want.done,
                 got.ch, got.valid, got.last, got.done);
        fail_count_o++;
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode = MODE_IDLE;
      clear_token();
      exp_chars_q.delete();
    end else begin
      if (push_i && !full_i) begin
        predict_byte(in_char_i, line_end_i);
      end
      if (pop_i && !empty_i) begin
        compare_char();
      end
    end
    pending_o = exp_chars_q.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse line translator testbench
// Sends directed and random text and Morse lines through the translator with
// random gaps and stalls on both sides and a long output hold-off, and lets
// the line checker predict and compare every result transaction.
// ----------------------------------------------------------------------------
module tb;
  import mct_pkg::*;

  localparam int WD_LIMIT    = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 40;
  localparam int DRAIN_WAIT  = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_char;
  logic       line_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last;
  logic       line_done;

  int fail_count;
  int pending;
  int results;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int idle_cycles;
  int n_bytes;
  int n_lines;

  logic [7:0] line_q[$];

  morse_code_translator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_char_i   (in_char),
    .line_end_i  (line_end),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char),
    .char_valid_o(char_valid),
    .last_o      (last),
    .line_done_o (line_done)
  );

  morse_line_checker line_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .in_char_i   (in_char),
    .line_end_i  (line_end),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_char_i  (out_char),
    .char_valid_i(char_valid),
    .last_i      (last),
    .line_done_i (line_done),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    pop       = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    in_char  <= c;
    line_end <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    n_bytes++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_byte(line_q[i], i == line_q.size() - 1);
    end
    n_lines++;
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
    send_line();
  endtask

  task automatic make_random_line();
    int kind;
    int n_tok;
    int sym_len;
    int n_chr;
    int r;
    line_q.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      n_tok = $urandom_range(4, 1);
      for (int t = 0; t < n_tok; t++) begin
        sym_len = ($urandom_range(9) == 0) ? $urandom_range(6, 5) : $urandom_range(4, 1);
        for (int s = 0; s < sym_len; s++) begin
          line_q.push_back($urandom_range(1) ? CH_DASH : CH_DOT);
        end
        if ($urandom_range(9) == 0) begin
          line_q.push_back(8'($urandom_range(255)));
        end
        if (t < n_tok - 1 || $urandom_range(3) == 0) begin
          repeat ($urandom_range(2, 1)) line_q.push_back(CH_SPACE);
        end
      end
    end else if (kind < 85) begin
      n_chr = $urandom_range(8, 1);
      for (int i = 0; i < n_chr; i++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          line_q.push_back(CH_UA + 8'($urandom_range(25)));
        end else if (r < 65) begin
          line_q.push_back(CH_LA + 8'($urandom_range(25)));
        end else if (r < 80) begin
          line_q.push_back(CH_SPACE);
        end else begin
          line_q.push_back(8'($urandom_range(255)));
        end
      end
    end else begin
      n_chr = $urandom_range(6, 1);
      for (int i = 0; i < n_chr; i++) begin
        line_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(3) == 0) begin
        line_q[0] = CH_DOT;
      end
    end
  endtask

  task automatic send_random(input int n_items);
    int start;
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      make_random_line();
      send_line();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    in_char       = 8'h00;
    line_end      = 1'b0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    n_bytes       = 0;
    n_lines       = 0;
    send_idle_pct = 31;
    recv_idle_pct = 79;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encode line opened by a foreign byte, with lowercase and a zero byte.
    line_q.delete();
    line_q.push_back(8'hFF);
    line_q.push_back(CH_LA);
    line_q.push_back(CH_NUL);
    line_q.push_back(CH_UZ);
    send_line();
    send_text(".- -.-.-");
    send_text("-x  ");
    send_text("..--");
    send_text(". xy");
    send_text(".");
    send_text(" ");
    send_random(PHASE_ITEMS);

    send_idle_pct = 79;
    recv_idle_pct = 31;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    send_random(PHASE_ITEMS);
    push <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Sent %0d bytes in %0d encode, decode and noise lines; checked %0d results.",
             n_bytes, n_lines, results);
    $display("Both sides idled at random, and the output was held off for %0d cycles.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
